// ===== rtl/multiscale_peak_coincidence_merge_top_macros.svh =====
// Assertion macros for the peak coincidence merge block; clk and rst_n come from the user's scope.
`ifndef MULTISCALE_PEAK_COINCIDENCE_MERGE_TOP_MACROS_SVH
`define MULTISCALE_PEAK_COINCIDENCE_MERGE_TOP_MACROS_SVH

// Same-cycle implication, held off during reset.
`define MPCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define MPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mpcm_pkg.sv =====
// Shared types and constants for the multiscale peak coincidence merge block.
`timescale 1ns / 1ps
`default_nettype none

package mpcm_pkg;

    localparam int NUM_SCALES  = 4;
    localparam int SCALE_W     = 2;
    localparam int FIELD_POS_W = 24;
    localparam int RULE_W      = 3;
    localparam int WINDOW_W    = 10;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 10'd20;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [RULE_W-1:0] {
        RULE_ALL  = 3'd0,
        RULE_S123 = 3'd1,
        RULE_S124 = 3'd2,
        RULE_S134 = 3'd3,
        RULE_S234 = 3'd4
    } rule_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_ACT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                   operation;
        logic [SCALE_W-1:0]     scale;
        logic [FIELD_POS_W-1:0] position;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_POS_W-1:0] match_position;
        logic [RULE_W-1:0]      match_rule;
        logic                   overflow;
        logic                   record_done;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic cmp;
        logic act;
        logic done;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic can_decide;
        logic all_done;
        logic slot_ok;
        logic act_emits;
        logic pend_valid;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/multiscale_peak_coincidence_merge_top.sv =====
// Top level of the multiscale peak coincidence merge block.
// Each item runs through accept, then check / compare / act per merge decision,
//   then a final check and flush.
// Throughput: one item at a time; the next is taken once the last result is staged.
// Output stalls add cycles only when a second result waits behind an untaken one.
// Reset (rst_n, async, low): queues empty, no scale ended, match_window = 20.
`timescale 1ns / 1ps
`default_nettype none

`include "multiscale_peak_coincidence_merge_top_macros.svh"

module multiscale_peak_coincidence_merge_top #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items: push a position or end one scale's list
    input  logic                          item_valid,
    output logic                          item_stall,
    input  mpcm_pkg::in_item_t            item,
    // result items
    output logic                          result_valid,
    input  logic                          result_stall,
    output mpcm_pkg::out_item_t           result,
    // coincidence window: write only while idle; the block does not enforce this
    input  logic                          match_window_we,
    input  logic [mpcm_pkg::WINDOW_W-1:0] match_window_data
);

    import mpcm_pkg::*;

    // Controller and datapath talk only through these two bundles.
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // The controller runs one item through: accept, then repeated decision rounds
    // while every live scale has a head, then the record-done check, then flush.
    mpcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // The datapath holds one queue memory per scale, reads all four heads each
    // cycle, registers the rule decision, and stages results. The newest result
    // sits in a pending register so that the last flag can be set at flush time.
    mpcm_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .item              (item),
        .match_window_we   (match_window_we),
        .match_window_data (match_window_data),
        .result            (result),
        .result_valid      (result_valid),
        .result_stall      (result_stall)
    );

    // Once an item is taken the block is busy for at least its check and flush.
    `MPCM_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall,
        "block took a second item straight after the first")

    // Record done is always the final result of its item.
    `MPCM_ASSERT_SAME(a_done_is_last, result_valid && result.record_done, result.last,
        "record done result without last")

    // When ready for a new item, nothing may be left in the pending stage.
    `MPCM_ASSERT_SAME(a_idle_no_pending, !item_stall, !sts.pend_valid,
        "pending result left behind while idle")

endmodule

`default_nettype wire

// ===== rtl/mpcm_queue_ram.sv =====
// One scale's position queue storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mpcm_queue_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mpcm_datapath.sv =====
// Datapath: scale queues, head comparison, pop logic and result staging.
`timescale 1ns / 1ps
`default_nettype none

module mpcm_datapath #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mpcm_pkg::ctrl_cmd_t              cmd,
    output mpcm_pkg::dp_status_t             sts,
    input  mpcm_pkg::in_item_t               item,
    input  logic                             match_window_we,
    input  logic [mpcm_pkg::WINDOW_W-1:0]    match_window_data,
    output mpcm_pkg::out_item_t              result,
    output logic                             result_valid,
    input  logic                             result_stall
);

    import mpcm_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam int CMP_W = (POSITION_BITS > WINDOW_W) ? POSITION_BITS : WINDOW_W;

    // queue bookkeeping
    logic [CNT_W-1:0]      count_reg [NUM_SCALES];
    logic [CNT_W-1:0]      count_next [NUM_SCALES];
    logic [PTR_W-1:0]      head_reg [NUM_SCALES];
    logic [PTR_W-1:0]      head_next [NUM_SCALES];
    logic [NUM_SCALES-1:0] ended_reg;
    logic [NUM_SCALES-1:0] ended_next;
    logic [WINDOW_W-1:0]   window_reg;
    logic [WINDOW_W-1:0]   window_next;

    // decision registers loaded in the compare step
    logic [NUM_SCALES-1:0]    pop_reg;
    logic [NUM_SCALES-1:0]    pop_next;
    logic                     emit_reg;
    logic                     emit_next;
    rule_t                    rule_reg;
    rule_t                    rule_next;
    logic [POSITION_BITS-1:0] mpos_reg;
    logic [POSITION_BITS-1:0] mpos_next;

    // result staging: one pending item, one output item
    out_item_t           pend_reg;
    out_item_t           pend_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    out_item_t           out_reg;
    out_item_t           out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_next;

    logic [POSITION_BITS-1:0] head_data [NUM_SCALES];
    logic [NUM_SCALES-1:0]    present;
    logic [NUM_SCALES-1:0]    ram_we;
    logic [SUM_W-1:0]         tail_sum;
    logic [PTR_W-1:0]         tail_ptr;
    logic                     queue_full;
    logic [POSITION_BITS-1:0] push_data;

    logic c12, c13, c14, c23, c24, c34;
    logic lt12, lt13, lt14, lt23, lt24, lt34;
    logic [NUM_SCALES-1:0]    pick_pop;
    logic                     pick_emit;
    rule_t                    pick_rule;
    logic [POSITION_BITS-1:0] pick_pos;

    logic                 new_valid;
    out_item_t            new_item;
    logic [RES_CNT_W-1:0] base_cnt;
    logic                 cnt_ok;

    function automatic logic near_f(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b,
        input logic                     pa,
        input logic                     pb,
        input logic [WINDOW_W-1:0]      win
    );
        logic [POSITION_BITS-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return pa && pb && (CMP_W'(d) < CMP_W'(win));
    endfunction

    // an absent head (ended, empty) is larger than any real position
    function automatic logic lt_f(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b,
        input logic                     pa,
        input logic                     pb
    );
        return pa && (!pb || (a < b));
    endfunction

    assign tail_sum   = SUM_W'(head_reg[item.scale]) + SUM_W'(count_reg[item.scale]);
    assign tail_ptr   = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                        PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign queue_full = (count_reg[item.scale] == CNT_W'(QUEUE_DEPTH));
    assign push_data  = POSITION_BITS'(item.position);

    genvar gs;
    generate
        for (gs = 0; gs < NUM_SCALES; gs++)
        begin : g_scale
            assign present[gs] = (count_reg[gs] != '0);
            assign ram_we[gs]  = cmd.accept && (item.operation == OP_PUSH) && !queue_full &&
                                 (item.scale == SCALE_W'(gs));

            mpcm_queue_ram #(
                .DEPTH (QUEUE_DEPTH),
                .WIDTH (POSITION_BITS)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we[gs]),
                .waddr (tail_ptr),
                .wdata (push_data),
                .raddr (head_reg[gs]),
                .rdata (head_data[gs])
            );
        end
    endgenerate

    // pairwise distance and order of the four heads
    always_comb
    begin
        c12  = near_f(head_data[0], head_data[1], present[0], present[1], window_reg);
        c13  = near_f(head_data[0], head_data[2], present[0], present[2], window_reg);
        c14  = near_f(head_data[0], head_data[3], present[0], present[3], window_reg);
        c23  = near_f(head_data[1], head_data[2], present[1], present[2], window_reg);
        c24  = near_f(head_data[1], head_data[3], present[1], present[3], window_reg);
        c34  = near_f(head_data[2], head_data[3], present[2], present[3], window_reg);
        lt12 = lt_f(head_data[0], head_data[1], present[0], present[1]);
        lt13 = lt_f(head_data[0], head_data[2], present[0], present[2]);
        lt14 = lt_f(head_data[0], head_data[3], present[0], present[3]);
        lt23 = lt_f(head_data[1], head_data[2], present[1], present[2]);
        lt24 = lt_f(head_data[1], head_data[3], present[1], present[3]);
        lt34 = lt_f(head_data[2], head_data[3], present[2], present[3]);
    end

    // rule priority, falling back to popping the smallest head
    always_comb
    begin
        pick_emit = 1'b1;
        pick_rule = RULE_ALL;
        pick_pos  = head_data[0];
        pick_pop  = '0;
        if (c12 && c13 && c14 && c23 && c24 && c34)
        begin
            pick_pop = 4'b1111;
        end
        else if (c12 && c13 && c23)
        begin
            pick_rule = RULE_S123;
            pick_pop  = 4'b0111;
        end
        else if (c12 && c14 && c24)
        begin
            pick_rule = RULE_S124;
            pick_pop  = 4'b1011;
        end
        else if (c13 && c14 && c34)
        begin
            pick_rule = RULE_S134;
            pick_pop  = 4'b1101;
        end
        else if (c23 && c24 && c34)
        begin
            pick_rule = RULE_S234;
            pick_pos  = head_data[1];
            pick_pop  = 4'b1110;
        end
        else
        begin
            pick_emit = 1'b0;
            if (lt12 && lt13 && lt14)
            begin
                pick_pop = 4'b0001;
            end
            else if (lt23 && lt24)
            begin
                pick_pop = 4'b0010;
            end
            else if (lt34)
            begin
                pick_pop = 4'b0100;
            end
            else
            begin
                pick_pop = 4'b1000;
            end
        end
    end

    // new result source: overflow at accept, match at act, record done
    always_comb
    begin
        new_item  = '0;
        new_valid = 1'b0;
        if (cmd.accept && (item.operation == OP_PUSH) && queue_full)
        begin
            new_valid         = 1'b1;
            new_item.overflow = 1'b1;
        end
        else if (cmd.act && emit_reg)
        begin
            new_valid               = 1'b1;
            new_item.match_position = FIELD_POS_W'(mpos_reg);
            new_item.match_rule     = rule_reg;
        end
        else if (cmd.done)
        begin
            new_valid            = 1'b1;
            new_item.record_done = 1'b1;
        end
    end

    assign base_cnt = cmd.accept ? '0 : res_cnt_reg;
    assign cnt_ok   = (base_cnt < RES_CNT_W'(MAX_RESULTS));

    always_comb
    begin
        count_next      = count_reg;
        head_next       = head_reg;
        ended_next      = ended_reg;
        window_next     = window_reg;
        pop_next        = pop_reg;
        emit_next       = emit_reg;
        rule_next       = rule_reg;
        mpos_next       = mpos_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        res_cnt_next    = base_cnt;

        if (match_window_we)
        begin
            window_next = match_window_data;
        end

        if (cmd.accept)
        begin
            if (item.operation == OP_END)
            begin
                ended_next[item.scale] = 1'b1;
            end
            else if (!queue_full)
            begin
                count_next[item.scale] = count_reg[item.scale] + CNT_W'(1);
            end
        end

        if (cmd.cmp)
        begin
            pop_next  = pick_pop;
            emit_next = pick_emit;
            rule_next = pick_rule;
            mpos_next = pick_pos;
        end

        if (cmd.act)
        begin
            for (int s = 0; s < NUM_SCALES; s++)
            begin
                if (pop_reg[s] && present[s])
                begin
                    count_next[s] = count_reg[s] - CNT_W'(1);
                    head_next[s]  = (head_reg[s] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg[s] + PTR_W'(1);
                end
            end
        end

        if (cmd.done)
        begin
            for (int s = 0; s < NUM_SCALES; s++)
            begin
                count_next[s] = '0;
                head_next[s]  = '0;
            end
            ended_next = '0;
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        // a new result pushes the pending one out; only the final one gets last
        if (new_valid && cnt_ok)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_item;
            pend_valid_next = 1'b1;
            res_cnt_next    = base_cnt + RES_CNT_W'(1);
        end

        if (cmd.flush && pend_valid_reg)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SCALES; s++)
            begin
                count_reg[s] <= '0;
                head_reg[s]  <= '0;
            end
            ended_reg      <= '0;
            window_reg     <= WINDOW_RESET;
            pop_reg        <= '0;
            emit_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            head_reg       <= head_next;
            ended_reg      <= ended_next;
            window_reg     <= window_next;
            pop_reg        <= pop_next;
            emit_reg       <= emit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            res_cnt_reg    <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg <= rule_next;
        mpos_reg <= mpos_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        sts.can_decide = (|present) && ((present | ended_reg) == '1);
        sts.all_done   = (ended_reg == '1) && (present == '0);
        sts.slot_ok    = !pend_valid_reg || !out_valid_reg || !result_stall;
        sts.act_emits  = emit_reg && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));
        sts.pend_valid = pend_valid_reg;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/mpcm_ctrl.sv =====
// Controller: sequences accept, decision rounds, record done and result flush.
`timescale 1ns / 1ps
`default_nettype none

module mpcm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  mpcm_pkg::dp_status_t sts,
    output mpcm_pkg::ctrl_cmd_t  cmd
);

    import mpcm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.can_decide)
                begin
                    state_next = ST_CMP;
                end
                else if (sts.all_done)
                begin
                    if (sts.slot_ok)
                    begin
                        cmd.done   = 1'b1;
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (!sts.act_emits || sts.slot_ok)
                begin
                    cmd.act    = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_FLUSH:
            begin
                if (sts.slot_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/mpcm_merge_checker.sv =====
// Checker for the peak coincidence merge: predicts result items per input item and compares.
`timescale 1ns / 1ps

module mpcm_merge_checker #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  mpcm_pkg::in_item_t            item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  mpcm_pkg::out_item_t           result,
    input  logic                          match_window_we,
    input  logic [mpcm_pkg::WINDOW_W-1:0] match_window_data,
    output int                            fails,
    output int                            pending,
    output int                            n_checked,
    output int                            n_matches,
    output int                            n_overflow,
    output int                            n_records,
    output logic [4:0]                    rules_seen
);

    import mpcm_pkg::*;

    // head of a finished, empty scale sits beyond any real position
    localparam longint FAR = 64'd1 << 40;

    logic [FIELD_POS_W-1:0] slots [NUM_SCALES][DEPTH];
    int                     fill [NUM_SCALES];
    int                     rd_ptr [NUM_SCALES];
    bit                     ended [NUM_SCALES];
    logic [WINDOW_W-1:0]    window;

    out_item_t              results_owed [$];
    int                     step_n;

    function automatic longint head_pos(input int s);
        if (fill[s] == 0)
            return FAR;
        return longint'(slots[s][rd_ptr[s]]);
    endfunction

    function automatic bit close(input longint a, input longint b);
        longint d;
        if (a == FAR || b == FAR)
            return 1'b0;
        d = (a > b) ? a - b : b - a;
        return d < longint'(window);
    endfunction

    function automatic bit ready_to_decide();
        bit any;
        any = 1'b0;
        for (int s = 0; s < NUM_SCALES; s++)
        begin
            if (fill[s] > 0)
                any = 1'b1;
            else if (!ended[s])
                return 1'b0;
        end
        return any;
    endfunction

    task automatic pop_head(input int s);
        if (fill[s] != 0)
        begin
            rd_ptr[s] = (rd_ptr[s] + 1) % DEPTH;
            fill[s]   = fill[s] - 1;
        end
    endtask

    task automatic clear_scales();
        for (int s = 0; s < NUM_SCALES; s++)
        begin
            fill[s]   = 0;
            rd_ptr[s] = 0;
            ended[s]  = 1'b0;
        end
    endtask

    task automatic owe(input logic [FIELD_POS_W-1:0] pos, input rule_t rule,
                       input logic ovf, input logic done);
        out_item_t r;
        r.match_position = pos;
        r.match_rule     = rule;
        r.overflow       = ovf;
        r.record_done    = done;
        r.last           = 1'b0;
        if (step_n < MAX_RESULTS)
        begin
            results_owed.push_back(r);
            step_n++;
        end
    endtask

    // one input item: queue or end, then run merge decisions until stuck
    task automatic merge_step(input in_item_t it);
        longint    p [NUM_SCALES];
        bit        c12, c13, c14, c23, c24, c34;
        bit        all_done;
        int        lo;
        out_item_t tail;
        step_n = 0;
        if (it.operation == OP_PUSH)
        begin
            if (fill[it.scale] >= DEPTH)
                owe('0, RULE_ALL, 1'b1, 1'b0);
            else
            begin
                slots[it.scale][(rd_ptr[it.scale] + fill[it.scale]) % DEPTH] = it.position;
                fill[it.scale] = fill[it.scale] + 1;
            end
        end
        else
            ended[it.scale] = 1'b1;

        while (ready_to_decide())
        begin
            for (int s = 0; s < NUM_SCALES; s++)
                p[s] = head_pos(s);
            c12 = close(p[0], p[1]);
            c13 = close(p[0], p[2]);
            c14 = close(p[0], p[3]);
            c23 = close(p[1], p[2]);
            c24 = close(p[1], p[3]);
            c34 = close(p[2], p[3]);
            if (c12 && c13 && c14 && c23 && c24 && c34)
            begin
                owe(p[0][FIELD_POS_W-1:0], RULE_ALL, 1'b0, 1'b0);
                pop_head(0); pop_head(1); pop_head(2); pop_head(3);
            end
            else if (c12 && c13 && c23)
            begin
                owe(p[0][FIELD_POS_W-1:0], RULE_S123, 1'b0, 1'b0);
                pop_head(0); pop_head(1); pop_head(2);
            end
            else if (c12 && c14 && c24)
            begin
                owe(p[0][FIELD_POS_W-1:0], RULE_S124, 1'b0, 1'b0);
                pop_head(0); pop_head(1); pop_head(3);
            end
            else if (c13 && c14 && c34)
            begin
                owe(p[0][FIELD_POS_W-1:0], RULE_S134, 1'b0, 1'b0);
                pop_head(0); pop_head(2); pop_head(3);
            end
            else if (c23 && c24 && c34)
            begin
                owe(p[1][FIELD_POS_W-1:0], RULE_S234, 1'b0, 1'b0);
                pop_head(1); pop_head(2); pop_head(3);
            end
            else
            begin
                // smallest head goes; ties fall to the higher scale
                if (p[0] < p[1] && p[0] < p[2] && p[0] < p[3])
                    lo = 0;
                else if (p[1] < p[2] && p[1] < p[3])
                    lo = 1;
                else if (p[2] < p[3])
                    lo = 2;
                else
                    lo = 3;
                pop_head(lo);
            end
        end

        all_done = 1'b1;
        for (int s = 0; s < NUM_SCALES; s++)
            if (!ended[s] || fill[s] != 0)
                all_done = 1'b0;
        if (all_done)
        begin
            owe('0, RULE_ALL, 1'b0, 1'b1);
            clear_scales();
        end

        if (step_n > 0)
        begin
            tail      = results_owed.pop_back();
            tail.last = 1'b1;
            results_owed.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            clear_scales();
            window = WINDOW_RESET;
            results_owed.delete();
            fails      <= 0;
            pending    <= 0;
            n_checked  <= 0;
            n_matches  <= 0;
            n_overflow <= 0;
            n_records  <= 0;
            rules_seen <= '0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (results_owed.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: result with none owed: pos %h rule %0d",
                                 $realtime, result.match_position, result.match_rule,
                                 " ovf %b done %b last %b",
                                 result.overflow, result.record_done, result.last);
                    fails <= fails + 1;
                end
                else
                begin
                    want = results_owed.pop_front();
                    if (result.match_position !== want.match_position ||
                        result.match_rule     !== want.match_rule ||
                        result.overflow       !== want.overflow ||
                        result.record_done    !== want.record_done ||
                        result.last           !== want.last)
                    begin
                        if (fails < 10)
                        begin
                            $display("%0t: mismatch exp pos %h rule %0d ovf %b done %b last %b",
                                     $realtime, want.match_position, want.match_rule,
                                     want.overflow, want.record_done, want.last);
                            $display("%0t:          got pos %h rule %0d ovf %b done %b last %b",
                                     $realtime, result.match_position, result.match_rule,
                                     result.overflow, result.record_done, result.last);
                        end
                        fails <= fails + 1;
                    end
                    n_checked <= n_checked + 1;
                    if (want.overflow)
                        n_overflow <= n_overflow + 1;
                    else if (want.record_done)
                        n_records <= n_records + 1;
                    else
                    begin
                        n_matches <= n_matches + 1;
                        rules_seen[want.match_rule] <= 1'b1;
                    end
                end
            end
            if (item_valid && !item_stall)
                merge_step(item);
            if (match_window_we)
                window = match_window_data;
            pending <= results_owed.size();
        end
    end

endmodule

// ===== test/tb_multiscale_peak_coincidence_merge_top.sv =====
// Testbench top for the peak coincidence merge: clock, reset, stimulus, window phases, verdict.
`timescale 1ns / 1ps

module tb_multiscale_peak_coincidence_merge_top;
    import mpcm_pkg::*;

    // quiet time after the last owed result: one item may still be popping
    // heads with no result (up to 64 queued heads)
    localparam int DRAIN_CYCLES   = 250;
    // cycles with no item, result or window write before we give up
    localparam int WATCHDOG_LIMIT = 3000;

    logic                clk               = 1'b0;
    logic                rst_n             = 1'b0;
    logic                item_valid        = 1'b0;
    logic                item_stall;
    in_item_t            item              = '0;
    logic                result_valid;
    logic                result_stall      = 1'b0;
    out_item_t           result;
    logic                match_window_we   = 1'b0;
    logic [WINDOW_W-1:0] match_window_data = '0;

    int         fails, pending, n_checked, n_matches, n_overflow, n_records;
    logic [4:0] rules_seen;

    int items_sent  = 0;
    int idle_cycles = 0;
    int stall_cnt   = 0;
    int cur_window  = 20;
    bit calm        = 1'b0;   // set for the final phase: no gaps, no stalls

    always #5 clk = ~clk;

    multiscale_peak_coincidence_merge_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .match_window_we   (match_window_we),
        .match_window_data (match_window_data)
    );

    mpcm_merge_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .match_window_we   (match_window_we),
        .match_window_data (match_window_data),
        .fails             (fails),
        .pending           (pending),
        .n_checked         (n_checked),
        .n_matches         (n_matches),
        .n_overflow        (n_overflow),
        .n_records         (n_records),
        .rules_seen        (rules_seen)
    );

    // Result back-pressure: stall bursts separated by free stretches, now and
    // then a long free one so the block runs flat out.
    always @(negedge clk)
    begin
        if (!rst_n || calm)
            result_stall <= 1'b0;
        else if (stall_cnt > 0)
            stall_cnt = stall_cnt - 1;
        else if (result_stall)
        begin
            result_stall <= 1'b0;
            stall_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(0, 30);
        end
        else
        begin
            result_stall <= 1'b1;
            stall_cnt = $urandom_range(0, 16);
        end
    end

    // Watchdog: any handshake or window write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
            match_window_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one item at a falling edge and hold it until taken. Returns at
    // the falling edge after acceptance with nothing yet driven in that step,
    // so valid stays high into the next item unless that one draws a random gap.
    task automatic send(input logic op, input int sc, input int pos);
        in_item_t nxt;
        int       gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 17);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        nxt.operation = op;
        nxt.scale     = sc[SCALE_W-1:0];
        nxt.position  = pos[FIELD_POS_W-1:0];
        item_valid <= 1'b1;
        item       <= nxt;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_window(input int v);
        settle();
        match_window_we   <= 1'b1;
        match_window_data <= v[WINDOW_W-1:0];
        cur_window = v;
        @(negedge clk);
        match_window_we <= 1'b0;
    endtask

    // A well-formed record: clusters of peaks around ascending centres, each
    // scale present with 3/4 odds and jittered inside the window. Sometimes one
    // scale lags and its peaks arrive in batches; then every scale ends, with
    // the odd repeated end marker and push onto an already ended scale.
    task automatic make_record();
        int w, n_cl, centre, lag, rot, dir, s, pos;
        int lag_pos [$];
        w      = (cur_window < 1) ? 1 : cur_window;
        n_cl   = $urandom_range(2, 10);
        centre = $urandom_range(4096, 24'hE00000);
        lag    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : -1;
        for (int k = 0; k < n_cl; k++)
        begin
            centre = centre + 3 * w + 10 + $urandom_range(0, 2 * w + 40);
            rot    = $urandom_range(0, 3);
            dir    = $urandom_range(0, 1);
            for (int i = 0; i < NUM_SCALES; i++)
            begin
                s = dir ? (rot + i) % NUM_SCALES : (rot + NUM_SCALES - i) % NUM_SCALES;
                if ($urandom_range(0, 3) != 0)
                begin
                    pos = centre + $urandom_range(0, w) - w / 2;
                    if ($urandom_range(0, 9) == 0)
                        pos = centre + w;          // just outside the cluster
                    if (s == lag)
                        lag_pos.push_back(pos);
                    else
                        send(OP_PUSH, s, pos);
                end
            end
            if (lag >= 0 && k % 5 == 4)
                while (lag_pos.size() > 0)
                    send(OP_PUSH, lag, lag_pos.pop_front());
        end
        while (lag_pos.size() > 0)
            send(OP_PUSH, lag, lag_pos.pop_front());

        rot = $urandom_range(0, 3);
        dir = $urandom_range(0, 1);
        for (int i = 0; i < NUM_SCALES; i++)
        begin
            s = dir ? (rot + i) % NUM_SCALES : (rot + NUM_SCALES - i) % NUM_SCALES;
            send(OP_END, s, $urandom_range(0, 24'hFFFFFF));
            if ($urandom_range(0, 4) == 0)
                send(OP_END, s, $urandom_range(0, 24'hFFFFFF));
            if (i == 2 && $urandom_range(0, 4) == 0)
                send(OP_PUSH, rot, centre + 5 * w + 100);
        end
    endtask

    // Broken record: one scale floods past its queue depth while the others
    // stay silent, so pushes get dropped, then all scales end.
    task automatic flood_record();
        int s, n, base;
        s    = $urandom_range(0, 3);
        n    = 16 + $urandom_range(1, 4);
        base = $urandom_range(0, 24'hF00000);
        for (int i = 0; i < n; i++)
            send(OP_PUSH, s, base + 3 * i);
        for (int i = 0; i < NUM_SCALES; i++)
            send(OP_END, i, $urandom_range(0, 24'hFFFFFF));
    endtask

    initial
    begin : stimulus
        int w;
        int phase_goal;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset window of 20.
        // all four coincide
        send(OP_PUSH, 0, 100);
        send(OP_PUSH, 1, 105);
        send(OP_PUSH, 2, 110);
        send(OP_PUSH, 3, 115);
        // scales 1-2-3 coincide, scale 4 head left behind
        send(OP_PUSH, 0, 200);
        send(OP_PUSH, 1, 210);
        send(OP_PUSH, 2, 205);
        send(OP_PUSH, 3, 500);
        // scales 2-3-4 around 490..500, scale 1 far away
        send(OP_PUSH, 1, 490);
        send(OP_PUSH, 2, 495);
        send(OP_PUSH, 0, 800);
        // scales 1-2-4, scale 3 too far
        send(OP_PUSH, 1, 805);
        send(OP_PUSH, 3, 810);
        send(OP_PUSH, 2, 900);
        // scales 1-3-4, scale 2 too far
        send(OP_PUSH, 0, 905);
        send(OP_PUSH, 3, 910);
        send(OP_PUSH, 1, 1200);
        // ends: repeated marker, empty finished scales, last end drains and closes
        send(OP_END, 1, 0);
        send(OP_END, 1, 24'hFFFFFF);
        send(OP_END, 2, 0);
        send(OP_END, 3, 0);
        send(OP_END, 0, 0);
        // position extremes
        send(OP_PUSH, 3, 24'hFFFFFF);
        send(OP_PUSH, 0, 0);
        send(OP_PUSH, 1, 0);
        send(OP_PUSH, 2, 0);

        // Random phases: zero window, narrowest, widest, two random, reset value.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: w = 0;
                1: w = 1;
                2: w = 1023;
                3: w = $urandom_range(2, 100);
                4: w = $urandom_range(101, 1022);
                default: w = 20;
            endcase
            write_window(w);
            if (ph == 5)
                calm = 1'b1;
            if (ph == 0)
                flood_record();
            phase_goal = 26 + (ph + 1) * 76;
            while (items_sent < phase_goal)
            begin
                // stray items between records
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3))
                        send(1'($urandom_range(0, 1)), $urandom_range(0, 3),
                             $urandom_range(0, 24'hFFFFFF));
                if ($urandom_range(0, 7) == 0)
                    flood_record();
                else
                    make_record();
            end
        end

        settle();
        $display("Checked %0d results over %0d items, windows 0, 1, 1023, two random and 20.",
                 n_checked, items_sent);
        $display("Matches %0d (rules seen %b), dropped pushes %0d, records closed %0d.",
                 n_matches, rules_seen, n_overflow, n_records);
        if (pending != 0)
            $display("%0d results still owed by the block at the end", pending);
        if (fails == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
